// ----- rtl/ipps_pkg.sv -----
// Shared constants and types for the IMU packet parser and scaler.
package ipps_pkg;

   // Framing bytes
   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_ACC   = 8'h51;
   localparam logic [7:0] TYPE_RATE  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   // Body layout: ten bytes, the first seven are kept, the last is the checksum
   localparam int unsigned BODY_LEN   = 10;
   localparam int unsigned STORE_LEN  = 7;
   localparam logic [3:0]  LAST_INDEX = 4'(BODY_LEN - 1);

   // Field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned RAW_W   = 16;
   localparam int unsigned AXIS_W  = 20;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned PROD_W  = 23;  // signed raw value times the scale numerator
   localparam int unsigned MAG_W   = 22;

   // Division by five as multiply by reciprocal: exact for dividends below 2^21/3
   localparam int unsigned      RECIP_SHIFT = 21;
   localparam int unsigned      RECIP_W     = 19;
   localparam logic [RECIP_W-1:0] RECIP_FIVE = 19'd419431;

   // Result kind codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ACC   = 2'd0,
      KIND_RATE  = 2'd1,
      KIND_ANGLE = 2'd2
   } kind_type;

endpackage

// ----- rtl/ipps_scale.sv -----
// One axis lane: scales a signed 16-bit raw value to units of 1/256, rounded to nearest.
module ipps_scale (
   input  logic signed [ipps_pkg::RAW_W-1:0]  raw,
   input  ipps_pkg::kind_type                 kind,
   output logic signed [ipps_pkg::AXIS_W-1:0] value
);
   import ipps_pkg::*;

   localparam int unsigned ACC_M_W = MAG_W - 3;
   localparam int unsigned ACC_P_W = ACC_M_W + RECIP_W;

   logic signed [PROD_W-1:0] raw_ext;
   logic signed [PROD_W-1:0] prod;
   logic                     neg;
   logic [MAG_W-1:0]         mag;
   logic [MAG_W-1:0]         mag_rnd;
   logic [ACC_M_W-1:0]       acc_eighth;
   logic [ACC_P_W-1:0]       acc_prod;
   logic [AXIS_W-1:0]        quot;

   assign raw_ext = $signed({{(PROD_W-RAW_W){raw[RAW_W-1]}}, raw});

   // Multiply by the numerator with shift-and-add: 49, 125 or 45
   always_comb begin
      case (kind)
         KIND_ACC:   prod = (raw_ext <<< 6) - (raw_ext <<< 4) + raw_ext;
         KIND_RATE:  prod = (raw_ext <<< 7) - (raw_ext <<< 2) + raw_ext;
         KIND_ANGLE: prod = (raw_ext <<< 5) + (raw_ext <<< 3) + (raw_ext <<< 2) + raw_ext;
         default:    prod = '0;
      endcase
   end

   // Round the magnitude so ties go away from zero
   assign neg = prod[PROD_W-1];
   assign mag = neg ? MAG_W'(-prod) : prod[MAG_W-1:0];

   always_comb begin
      case (kind)
         KIND_ACC:   mag_rnd = mag + MAG_W'(20);
         KIND_RATE:  mag_rnd = mag + MAG_W'(4);
         KIND_ANGLE: mag_rnd = mag + MAG_W'(16);
         default:    mag_rnd = mag;
      endcase
   end

   // Divide by 40 as a shift by three and a reciprocal multiply by one fifth
   assign acc_eighth = ACC_M_W'(mag_rnd >> 3);
   assign acc_prod   = ACC_P_W'(acc_eighth) * ACC_P_W'(RECIP_FIVE);

   always_comb begin
      case (kind)
         KIND_ACC:   quot = AXIS_W'(acc_prod >> RECIP_SHIFT);
         KIND_RATE:  quot = AXIS_W'(mag_rnd >> 3);
         KIND_ANGLE: quot = AXIS_W'(mag_rnd >> 5);
         default:    quot = '0;
      endcase
   end

   // Restore the sign
   assign value = neg ? $signed(-quot) : $signed(quot);

endmodule

// ----- rtl/imu_packet_parser_scaler_unit.sv -----
// Top level of the IMU packet parser and scaler: byte framing, checksum and result register.
//
//   channel  | direction | handshake              | payload
//   req_     | in        | req_tvalid/req_tready  | tdata[7:0] rx_byte
//   rsp_     | out       | rsp_tvalid/rsp_tready  | tdata: axis_x, axis_y, axis_z; tuser: kind
//
// One byte word is taken per cycle. A result appears in the cycle after the checksum byte.
// The body registers feed the three scaling lanes directly into the result register.
// Reset returns the framer to header hunting and empties the result register.
// A waiting result stalls only a checksum byte; all other bytes keep flowing.
module imu_packet_parser_scaler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [19:0] axis_x, [39:20] axis_y, [59:40] axis_z, [63:60] zero
   output logic [7:0]  rsp_tuser    // [1:0] kind, [7:2] zero
);
   import ipps_pkg::*;

   logic                     collecting_ff, collecting_in;
   logic [3:0]               count_ff, count_in;
   logic [BYTE_W-1:0]        sum_ff, sum_in;
   logic [BYTE_W-1:0]        store_ff [STORE_LEN];
   logic                     rsp_valid_ff, rsp_valid_in;
   kind_type                 kind_ff;
   logic signed [AXIS_W-1:0] x_ff, y_ff, z_ff;

   logic                     last_byte;
   logic                     accept;
   logic                     type_known;
   logic                     emit;
   kind_type                 kind_dec;
   logic signed [AXIS_W-1:0] x_val, y_val, z_val;
   logic [BYTE_W-1:0]        rx_byte;

   assign rx_byte   = req_tdata;
   assign last_byte = collecting_ff && (count_ff == LAST_INDEX);
   assign req_tready = !last_byte || !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   // Decode the packet type from body byte zero
   always_comb begin
      type_known = 1'b1;
      case (store_ff[0])
         TYPE_ACC:   kind_dec = KIND_ACC;
         TYPE_RATE:  kind_dec = KIND_RATE;
         TYPE_ANGLE: kind_dec = KIND_ANGLE;
         default: begin
            kind_dec   = KIND_ACC;
            type_known = 1'b0;
         end
      endcase
   end

   assign emit = accept && last_byte && (sum_ff == rx_byte) && type_known;

   // Scale the three little-endian words
   ipps_scale u_scale_x (
      .raw   ($signed({store_ff[2], store_ff[1]})),
      .kind  (kind_dec),
      .value (x_val)
   );
   ipps_scale u_scale_y (
      .raw   ($signed({store_ff[4], store_ff[3]})),
      .kind  (kind_dec),
      .value (y_val)
   );
   ipps_scale u_scale_z (
      .raw   ($signed({store_ff[6], store_ff[5]})),
      .kind  (kind_dec),
      .value (z_val)
   );

   // Framing next state: hunt, collect, check
   always_comb begin
      collecting_in = collecting_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      if (accept) begin
         if (!collecting_ff) begin
            if (rx_byte == HDR_BYTE) begin
               collecting_in = 1'b1;
               count_in      = '0;
               sum_in        = HDR_BYTE;
            end
         end else if (!last_byte) begin
            sum_in   = sum_ff + rx_byte;
            count_in = count_ff + 4'd1;
         end else begin
            collecting_in = 1'b0;
            count_in      = '0;
            sum_in        = HDR_BYTE;
         end
      end
   end

   // Hold the result word until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= HDR_BYTE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture body bytes zero to six
   always_ff @(posedge clock) begin
      if (accept && collecting_ff && (count_ff < 4'(STORE_LEN))) begin
         store_ff[count_ff[2:0]] <= rx_byte;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_dec;
         x_ff    <= x_val;
         y_ff    <= y_val;
         z_ff    <= z_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, z_ff, y_ff, x_ff};
   assign rsp_tuser  = {6'b000000, kind_ff};

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_INDEX)
      else $error("body count beyond the checksum byte");

   a_hunt_count_zero: assert property (@(posedge clock) disable iff (reset)
      !collecting_ff |-> count_ff == 4'd0)
      else $error("body count nonzero while hunting");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_tvalid)
      else $error("good packet produced no result word");

   a_check_stalls: assert property (@(posedge clock) disable iff (reset)
      (last_byte && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("checksum byte taken while a result word is blocked");

   a_header_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && !collecting_ff && rx_byte == HDR_BYTE)
      |=> (collecting_ff && count_ff == 4'd0 && sum_ff == HDR_BYTE))
      else $error("header byte did not start a packet");

endmodule

// ----- bench/imu_packet_parser_scaler_unit_check.sv -----
// Checker for the IMU packet parser: frames the byte stream, predicts scaled samples, compares.
module imu_packet_parser_scaler_unit_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [19:0] axis_x, [39:20] axis_y, [59:40] axis_z, [63:60] zero
   input  logic [7:0]  rsp_tuser,   // [1:0] kind, [7:2] zero
   output int          mismatch_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import ipps_pkg::*;

   localparam int unsigned PRINT_CAP = 40;

   typedef struct {
      kind_type                   kind;
      logic signed [AXIS_W-1:0]   axis_x;
      logic signed [AXIS_W-1:0]   axis_y;
      logic signed [AXIS_W-1:0]   axis_z;
   } motion_sample_type;

   motion_sample_type expected_samples[$];
   int                fail_total = 0;
   int                queued_total = 0;

   // Framer state
   bit                in_packet;
   int unsigned       body_index;
   logic [7:0]        body_sum;
   logic [7:0]        body_bytes[STORE_LEN];

   assign mismatch_count  = fail_total;
   assign pending_results = queued_total;

   // Print one line per mismatch, up to a cap, and count every one
   task automatic report_mismatch(input string what);
      if (fail_total < PRINT_CAP)
         $display("%0t mismatch: %s", $realtime, what);
      fail_total++;
   endtask

   // Scale a raw 16-bit reading by num/den, rounding to nearest, ties away from zero
   function automatic logic signed [AXIS_W-1:0] scale_axis(input logic [15:0] raw,
                                                           input int num, input int den);
      int reading;
      int prod;
      int quot;
      reading = $signed(raw);
      prod = reading * num;
      if (prod >= 0)
         quot = (prod + den / 2) / den;
      else
         quot = -((-prod + den / 2) / den);
      return quot[AXIS_W-1:0];
   endfunction

   // Advance the framer by one byte word; queue a sample on a good packet of known type
   task automatic track_byte(input logic [7:0] rx);
      motion_sample_type sample;
      int                num;
      int                den;
      bit                keep;
      if (!in_packet) begin
         if (rx == HDR_BYTE) begin
            in_packet  = 1'b1;
            body_index = 0;
            body_sum   = HDR_BYTE;
         end
      end else if (body_index < BODY_LEN - 1) begin
         if (body_index < STORE_LEN)
            body_bytes[body_index] = rx;
         body_sum   = body_sum + rx;
         body_index = body_index + 1;
      end else begin
         // checksum byte closes the packet either way
         in_packet  = 1'b0;
         body_index = 0;
         keep       = (body_sum == rx);
         body_sum   = HDR_BYTE;
         num        = 1;
         den        = 1;
         case (body_bytes[0])
            TYPE_ACC: begin
               sample.kind = KIND_ACC;   num = 49;  den = 40;  // 16 g * 9.8 over full scale
            end
            TYPE_RATE: begin
               sample.kind = KIND_RATE;  num = 125; den = 8;   // 2000 deg/s over full scale
            end
            TYPE_ANGLE: begin
               sample.kind = KIND_ANGLE; num = 45;  den = 32;  // 180 deg over full scale
            end
            default: keep = 1'b0;
         endcase
         if (keep) begin
            sample.axis_x = scale_axis({body_bytes[2], body_bytes[1]}, num, den);
            sample.axis_y = scale_axis({body_bytes[4], body_bytes[3]}, num, den);
            sample.axis_z = scale_axis({body_bytes[6], body_bytes[5]}, num, den);
            expected_samples.push_back(sample);
         end
      end
   endtask

   // Compare one result word against the oldest expected sample
   task automatic compare_result();
      motion_sample_type want;
      if (expected_samples.size() == 0) begin
         report_mismatch($sformatf("unexpected result tdata=%h tuser=%h", rsp_tdata, rsp_tuser));
         return;
      end
      want = expected_samples.pop_front();
      if (rsp_tuser[1:0] != want.kind)
         report_mismatch($sformatf("kind %0d, want %0d", rsp_tuser[1:0], want.kind));
      if (rsp_tdata[19:0] != want.axis_x)
         report_mismatch($sformatf("axis_x %0d, want %0d",
                                   $signed(rsp_tdata[19:0]), want.axis_x));
      if (rsp_tdata[39:20] != want.axis_y)
         report_mismatch($sformatf("axis_y %0d, want %0d",
                                   $signed(rsp_tdata[39:20]), want.axis_y));
      if (rsp_tdata[59:40] != want.axis_z)
         report_mismatch($sformatf("axis_z %0d, want %0d",
                                   $signed(rsp_tdata[59:40]), want.axis_z));
      if (rsp_tdata[63:60] != 4'd0 || rsp_tuser[7:2] != 6'd0)
         report_mismatch($sformatf("nonzero pad bits tdata=%h tuser=%h", rsp_tdata, rsp_tuser));
   endtask

   // Watch both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         in_packet  = 1'b0;
         body_index = 0;
         body_sum   = HDR_BYTE;
         expected_samples.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            compare_result();
         if (req_tvalid && req_tready)
            track_byte(req_tdata);
      end
      queued_total = expected_samples.size();
   end

endmodule

// ----- bench/imu_packet_parser_scaler_unit_test.sv -----
// Testbench top for the IMU packet parser: clock, reset, byte stream stimulus and verdict.
module imu_packet_parser_scaler_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ipps_pkg::*;

   localparam int unsigned BYTE_TARGET  = 1450;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam logic [7:0]  KNOWN_TYPES[3] = '{TYPE_ACC, TYPE_RATE, TYPE_ANGLE};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [7:0]  rsp_tuser;

   int          mismatch_count;
   int          pending_results;
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   logic [7:0]  serial_bytes[$];

   imu_packet_parser_scaler_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   imu_packet_parser_scaler_unit_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // Clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("imu_packet_parser_scaler_unit_test: FAIL");
      $finish;
   end

   // Result side backpressure
   initial begin
      forever begin
         @(negedge clock);
         if (reset)
            rsp_tready <= 1'b0;
         else
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Append one framed packet; a nonzero sum_flip corrupts the checksum
   task automatic add_packet(input logic [7:0] type_byte, input logic [15:0] vx,
                             input logic [15:0] vy, input logic [15:0] vz,
                             input logic [7:0] sum_flip);
      logic [7:0] body[9];
      logic [7:0] sum;
      body[0] = type_byte;
      body[1] = vx[7:0];
      body[2] = vx[15:8];
      body[3] = vy[7:0];
      body[4] = vy[15:8];
      body[5] = vz[7:0];
      body[6] = vz[15:8];
      body[7] = 8'($urandom);
      body[8] = 8'($urandom);
      sum = HDR_BYTE;
      serial_bytes.push_back(HDR_BYTE);
      for (int i = 0; i < 9; i++) begin
         serial_bytes.push_back(body[i]);
         sum = sum + body[i];
      end
      serial_bytes.push_back(sum ^ sum_flip);
   endtask

   // Offer one byte word, idling first at the current rate, and hold until taken
   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] raw[3];
      logic [7:0]  type_byte;
      int unsigned pick;
      int unsigned total;

      // Directed: bytes ignored while hunting, full-scale and rounding-tie readings,
      // header values inside a body
      serial_bytes.push_back(8'h00);
      serial_bytes.push_back(8'hFF);
      add_packet(TYPE_ACC, 16'h7FFF, 16'h8000, 16'd20, 8'h00);
      add_packet(TYPE_RATE, 16'hFFFC, 16'h5555, 16'h0055, 8'h00);

      // Random: mostly good packets, some bad checksums, unknown types and noise
      while (serial_bytes.size() < BYTE_TARGET) begin
         for (int a = 0; a < 3; a++) begin
            case ($urandom_range(15))
               0:       raw[a] = 16'h7FFF;
               1:       raw[a] = 16'h8000;
               2:       raw[a] = 16'hFFFF;
               3:       raw[a] = 16'h0000;
               default: raw[a] = 16'($urandom);
            endcase
         end
         type_byte = KNOWN_TYPES[$urandom_range(2)];
         pick = $urandom_range(99);
         if (pick < 80) begin
            add_packet(type_byte, raw[0], raw[1], raw[2], 8'h00);
         end else if (pick < 88) begin
            add_packet(type_byte, raw[0], raw[1], raw[2], 8'($urandom_range(255, 1)));
         end else if (pick < 94) begin
            do type_byte = 8'($urandom);
            while (type_byte inside {TYPE_ACC, TYPE_RATE, TYPE_ANGLE});
            add_packet(type_byte, raw[0], raw[1], raw[2], 8'h00);
         end else begin
            repeat ($urandom_range(4, 1)) serial_bytes.push_back(8'($urandom));
         end
      end

      // Reset
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Stream the bytes through three idle regimes
      total = serial_bytes.size();
      for (int i = 0; i < total; i++) begin
         if (i < total / 3) begin
            tx_idle_pct = 34;
            rx_idle_pct = 79;
         end else if (i < 2 * total / 3) begin
            tx_idle_pct = 79;
            rx_idle_pct = 34;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         send_byte(serial_bytes[i]);
      end
      req_tvalid <= 1'b0;

      // Drain outstanding results, then allow for strays
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pending_results == 0)
         $display("imu_packet_parser_scaler_unit_test: PASS");
      else
         $display("imu_packet_parser_scaler_unit_test: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ipps_pkg.sv
rtl/ipps_scale.sv
rtl/imu_packet_parser_scaler_unit.sv
bench/imu_packet_parser_scaler_unit_check.sv
bench/imu_packet_parser_scaler_unit_test.sv
